[src/mwbs_pkg.sv]
package mwbs_pkg;

  localparam int unsigned SHORT_LEN     = 25;
  localparam int unsigned MID_LEN       = 50;
  localparam int unsigned LONG_LEN      = 250;
  localparam int unsigned HISTORY_DEPTH = 256;

  localparam int unsigned COUNT_W = 24;
  localparam int unsigned CUR_W   = 27;
  localparam int unsigned SHORT_W = 32;
  localparam int unsigned MID_W   = 33;
  localparam int unsigned LONG_W  = 35;

  localparam int unsigned SSUM_W = COUNT_W + $clog2(SHORT_LEN + 1);
  localparam int unsigned MSUM_W = COUNT_W + $clog2(MID_LEN + 1);
  localparam int unsigned LSUM_W = COUNT_W + $clog2(LONG_LEN + 1);

  localparam int unsigned PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned PTRX_W = PTR_W + 1;

  localparam int unsigned SHORT_BACK = SHORT_LEN % HISTORY_DEPTH;
  localparam int unsigned MID_BACK   = MID_LEN % HISTORY_DEPTH;
  localparam int unsigned LONG_BACK  = LONG_LEN % HISTORY_DEPTH;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [PTR_W-1:0]   ptr_t;

  typedef struct packed {
    count_t short_old;
    count_t mid_old;
    count_t long_old;
  } taps_t;

  function automatic ptr_t tap_addr(ptr_t wp, int unsigned back);
    logic [PTRX_W-1:0] sum;
    sum = {1'b0, wp} + PTRX_W'(HISTORY_DEPTH) - PTRX_W'(back);
    if (sum >= PTRX_W'(HISTORY_DEPTH)) begin
      sum = sum - PTRX_W'(HISTORY_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[src/mwbs_hist.sv]
module mwbs_hist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  mwbs_pkg::count_t wr_data_i,
  output mwbs_pkg::taps_t  taps_o
);
  import mwbs_pkg::*;

  count_t mem_a [HISTORY_DEPTH];
  count_t mem_b [HISTORY_DEPTH];

  ptr_t                     wp_q, wp_d;
  logic [HISTORY_DEPTH-1:0] vld_q, vld_d;
  ptr_t                     ra_short, ra_mid, ra_long;
  count_t                   rd_short_q, rd_mid_q, rd_long_q, fwd_q;
  logic [2:0]               hit_q, hit_d, ent_q, ent_d;

  always_comb begin
    if (!wr_en_i) begin
      wp_d = wp_q;
    end else if (wp_q == ptr_t'(HISTORY_DEPTH - 1)) begin
      wp_d = '0;
    end else begin
      wp_d = wp_q + ptr_t'(1);
    end
    ra_short = tap_addr(wp_d, SHORT_BACK);
    ra_mid   = tap_addr(wp_d, MID_BACK);
    ra_long  = tap_addr(wp_d, LONG_BACK);
    hit_d[0] = wr_en_i && (ra_short == wp_q);
    hit_d[1] = wr_en_i && (ra_mid == wp_q);
    hit_d[2] = wr_en_i && (ra_long == wp_q);
    ent_d[0] = vld_q[ra_short];
    ent_d[1] = vld_q[ra_mid];
    ent_d[2] = vld_q[ra_long];
    vld_d    = vld_q;
    if (wr_en_i) begin
      vld_d[wp_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wp_q] <= wr_data_i;
      mem_b[wp_q] <= wr_data_i;
    end
    rd_short_q <= mem_a[ra_short];
    rd_mid_q   <= mem_a[ra_mid];
    rd_long_q  <= mem_b[ra_long];
    fwd_q      <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      vld_q <= '0;
      hit_q <= '0;
      ent_q <= '0;
    end else begin
      wp_q  <= wp_d;
      vld_q <= vld_d;
      hit_q <= hit_d;
      ent_q <= ent_d;
    end
  end

  // forwarded write wins, unwritten entries read as zero
  assign taps_o.short_old = hit_q[0] ? fwd_q : (ent_q[0] ? rd_short_q : '0);
  assign taps_o.mid_old   = hit_q[1] ? fwd_q : (ent_q[1] ? rd_mid_q : '0);
  assign taps_o.long_old  = hit_q[2] ? fwd_q : (ent_q[2] ? rd_long_q : '0);

endmodule

[src/mwbs_accum.sv]
module mwbs_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mwbs_pkg::count_t              byte_count_i,
  input  mwbs_pkg::taps_t               taps_i,
  output logic                          accept_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mwbs_pkg::CUR_W-1:0]    current_bits_o,
  output logic [mwbs_pkg::SHORT_W-1:0]  short_window_bits_o,
  output logic [mwbs_pkg::MID_W-1:0]    mid_window_bits_o,
  output logic [mwbs_pkg::LONG_W-1:0]   long_window_bits_o
);
  import mwbs_pkg::*;

  logic [SSUM_W-1:0] ssum_q, ssum_d;
  logic [MSUM_W-1:0] msum_q, msum_d;
  logic [LSUM_W-1:0] lsum_q, lsum_d;
  logic              vld_q;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign accept_o    = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q;

  assign ssum_d = ssum_q + SSUM_W'(byte_count_i) - SSUM_W'(taps_i.short_old);
  assign msum_d = msum_q + MSUM_W'(byte_count_i) - MSUM_W'(taps_i.mid_old);
  assign lsum_d = lsum_q + LSUM_W'(byte_count_i) - LSUM_W'(taps_i.long_old);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssum_q <= '0;
      msum_q <= '0;
      lsum_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (accept_o) begin
        ssum_q <= ssum_d;
        msum_q <= msum_d;
        lsum_q <= lsum_d;
        vld_q  <= 1'b1;
      end else if (out_ready_i) begin
        vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      current_bits_o      <= CUR_W'({byte_count_i, 3'b000});
      short_window_bits_o <= SHORT_W'({ssum_d, 3'b000});
      mid_window_bits_o   <= MID_W'({msum_d, 3'b000});
      long_window_bits_o  <= LONG_W'({lsum_d, 3'b000});
    end
  end

endmodule

[src/multi_window_bitrate_sum.sv]
// channel  signals                               dir  width
// in       in_valid_i / in_ready_o, byte_count_i  in   24
// out      out_valid_o / out_ready_i, current_bits_o,
//          short/mid/long_window_bits_o           out  27/32/33/35
//
// One request per cycle unless the output stalls; result registered in the cycle after acceptance.
// Taps come from two history memories (two read ports + one), prefetched
// into registers from the next write position, with write forwarding.
// Reset clears sums, write position and per-entry valid bits at once.
// A stalled output holds; input is still taken when the output drains.
module multi_window_bitrate_sum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mwbs_pkg::COUNT_W-1:0]  byte_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mwbs_pkg::CUR_W-1:0]    current_bits_o,
  output logic [mwbs_pkg::SHORT_W-1:0]  short_window_bits_o,
  output logic [mwbs_pkg::MID_W-1:0]    mid_window_bits_o,
  output logic [mwbs_pkg::LONG_W-1:0]   long_window_bits_o
);
  import mwbs_pkg::*;

  taps_t taps;
  logic  accept;

  mwbs_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (byte_count_i),
    .taps_o    (taps)
  );

  mwbs_accum u_accum (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .byte_count_i        (byte_count_i),
    .taps_i              (taps),
    .accept_o            (accept),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .current_bits_o      (current_bits_o),
    .short_window_bits_o (short_window_bits_o),
    .mid_window_bits_o   (mid_window_bits_o),
    .long_window_bits_o  (long_window_bits_o)
  );

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request gave no result");

  a_bits_scaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (current_bits_o[2:0] == 3'b000) && (long_window_bits_o[2:0] == 3'b000))
    else $error("result not scaled to bits");

  a_windows_nested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MID_W'(short_window_bits_o) <= mid_window_bits_o)
                 && (LONG_W'(mid_window_bits_o) <= long_window_bits_o))
    else $error("window sums out of order");
`endif

endmodule
